FILE: design/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// shared types and constants for the packed sample unpacker
// ----------------------------------------------------------------------------
package psu_pkg;

    // most results one input byte can produce
    localparam int MAX_RES = 4;

    // default row length limit
    localparam int MAX_ROW_WIDTH_DEF = 65535;

    // configuration register indexes
    localparam logic [0:0] REG_SAMPLE_BITS = 1'd0;
    localparam logic [0:0] REG_ROW_WIDTH   = 1'd1;

    // reset values of the configuration registers
    localparam logic [3:0]  SAMPLE_BITS_RST = 4'd8;
    localparam logic [15:0] ROW_WIDTH_RST   = 16'd1;

    // one result entry
    typedef struct packed {
        logic [7:0] value;
        logic       row_done;
        logic       run_last;
    } psu_result_t;

endpackage

FILE: design/packed_sample_unpacker.sv
// ----------------------------------------------------------------------------
// packed_sample_unpacker
// splits a byte stream of raster rows into right-aligned samples of 1..8 bits
// ----------------------------------------------------------------------------
// Each input transaction carries one raw row byte (msb first) in s_tdata and a
// row start flag in s_tuser. The byte is shifted into a 16-bit accumulator and
// all samples it completes (at most four) are computed in the same cycle and
// written to a four-entry result buffer; from there one result transaction
// leaves per cycle while m_tready is high, the first in the cycle after the
// byte was accepted. A single result port drains the buffer, and a new byte
// is taken only when the buffer is empty or its last entry leaves in that
// cycle. A byte that yields no result (no row open, row finished) leaves the
// buffer empty. At one bit per sample each byte passes through unchanged,
// ceil(row_width/8) bytes per row. Bits and bytes past the end of a row are
// dropped. m_tlast marks the last result of a row and m_tuser the last result
// caused by one byte. The user must write configuration through cfg_we/
// cfg_addr/cfg_wdata only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module packed_sample_unpacker
    import psu_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] row_start

    // sample output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] sample_value
    output logic        m_tlast,   // row_done
    output logic        m_tuser    // [0] run_last
);

    localparam int CNT_W = $clog2(MAX_RES + 1);
    localparam int IDX_W = $clog2(MAX_RES);
    localparam logic [15:0] ROW_LIMIT = 16'(MAX_ROW_WIDTH);

    // configuration registers
    logic [3:0]  sample_bits_reg;
    logic [15:0] row_width_reg;

    // unpacking state
    logic [15:0] acc_reg, acc_next;
    logic [3:0]  held_reg, held_next;
    logic [15:0] left_reg, left_next;

    // result buffer
    psu_result_t           buf_reg [MAX_RES];
    psu_result_t           res_next [MAX_RES];
    logic [CNT_W-1:0]      cnt_reg, nres_next;
    logic [IDX_W-1:0]      rd_reg;

    logic        s_accept;
    logic        m_accept;
    logic [3:0]  eff_bits;
    logic        one_bit;
    logic [15:0] width_lim;
    logic [7:0]  mask;
    logic [16:0] width_sum;

    // effective sample size: zero acts as one, above eight saturates
    always_comb begin
        if (sample_bits_reg == 4'd0) begin
            eff_bits = 4'd1;
        end else if (sample_bits_reg > 4'd8) begin
            eff_bits = 4'd8;
        end else begin
            eff_bits = sample_bits_reg;
        end
    end

    assign one_bit   = (eff_bits == 4'd1);
    assign width_lim = (row_width_reg > ROW_LIMIT) ? ROW_LIMIT : row_width_reg;
    assign width_sum = {1'b0, width_lim} + 17'd7;
    assign mask      = 8'((9'd1 << eff_bits) - 9'd1);

    // handshakes: take a byte when the buffer is empty or its last entry leaves now
    assign m_tvalid = (cnt_reg != '0);
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign m_tdata = buf_reg[rd_reg].value;
    assign m_tlast = buf_reg[rd_reg].row_done;
    assign m_tuser = buf_reg[rd_reg].run_last;

    // single pass over one byte: row start, shift in, up to four extractions
    always_comb begin
        acc_next  = acc_reg;
        held_next = held_reg;
        left_next = left_reg;
        nres_next = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            res_next[k] = '0;
        end

        if (s_tuser) begin
            // one-bit mode counts whole bytes, rounded up
            left_next = one_bit ? {2'b00, width_sum[16:3]} : width_lim;
            acc_next  = '0;
            held_next = '0;
        end

        if (left_next != '0) begin
            if (one_bit) begin
                // packed byte passes through, counted per byte
                left_next            = left_next - 16'd1;
                res_next[0].value    = s_tdata;
                res_next[0].row_done = (left_next == '0);
                nres_next            = CNT_W'(1);
            end else begin
                // bits older than seven are lost after a size change
                if (held_next > 4'd7) begin
                    held_next = 4'd7;
                end
                acc_next  = {acc_next[7:0], s_tdata};
                held_next = held_next + 4'd8;
                for (int k = 0; k < MAX_RES; k++) begin
                    if ((held_next >= eff_bits) && (left_next != '0)) begin
                        held_next            = held_next - eff_bits;
                        left_next            = left_next - 16'd1;
                        res_next[k].value    = 8'(acc_next >> held_next) & mask;
                        res_next[k].row_done = (left_next == '0);
                        nres_next            = nres_next + CNT_W'(1);
                    end
                end
            end
        end

        // flag the last result produced by this byte
        for (int k = 0; k < MAX_RES; k++) begin
            res_next[k].run_last = (nres_next == CNT_W'(k + 1));
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_bits_reg <= SAMPLE_BITS_RST;
            row_width_reg   <= ROW_WIDTH_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SAMPLE_BITS: sample_bits_reg <= cfg_wdata[3:0];
                REG_ROW_WIDTH:   row_width_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // unpacking state, updated once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            held_reg <= '0;
            left_reg <= '0;
        end else if (s_accept) begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
            left_reg <= left_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (s_accept) begin
            cnt_reg <= nres_next;
            rd_reg  <= '0;
        end else if (m_accept) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rd_reg  <= rd_reg + IDX_W'(1);
        end
    end

    // result buffer payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int k = 0; k < MAX_RES; k++) begin
                buf_reg[k] <= res_next[k];
            end
        end
    end

`ifndef SYNTHESIS
    // buffer never holds more than one byte's results
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

    // the run_last entry is always the last one in the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (cnt_reg == CNT_W'(1)))
    else $error("run_last shown with results still queued");

    // end of row ends the byte's results too
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
    else $error("row_done without run_last");

    // a new byte is taken only when the buffer is empty or drains this cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ((cnt_reg == '0) || m_accept))
    else $error("byte accepted over pending results");

    // a finished row leaves no owed samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_tlast) |-> (left_reg == '0))
    else $error("row_done while samples still owed");
`endif

endmodule
